FILE: src/ps2mtc_pkg.sv
// Shared types, constants and helpers for the PS/2 mouse text cursor core.
package ps2mtc_pkg;

    // Controller status bit that marks a mouse data byte
    localparam int unsigned STATUS_MOUSE_BIT = 5;
    // Buttons 0..2 of the first packet byte
    localparam logic [7:0]  BUTTON_MASK      = 8'h07;

    // Configuration register indexes
    localparam logic        CFG_SCREEN_COLUMNS = 1'b0;
    localparam logic        CFG_SCREEN_ROWS    = 1'b1;

    // Reset values
    localparam logic [7:0]  COLS_RESET = 8'd80;
    localparam logic [6:0]  ROWS_RESET = 7'd25;
    localparam logic [6:0]  COL_RESET  = 7'd40;
    localparam logic [5:0]  ROW_RESET  = 6'd12;

    // Screen limits
    localparam logic [7:0]  COLS_MAX = 8'd128;
    localparam logic [6:0]  ROWS_MAX = 7'd64;

    // Packet queue between front and back
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned FIFO_AW    = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] buttons;
        logic [7:0] dx;
        logic [7:0] dy;
    } t_packet;

    // Effective screen size, already clamped to 1..128 and 1..64
    typedef struct packed {
        logic [7:0] cols;
        logic [6:0] rows;
    } t_screen;

    function automatic logic [7:0] clamp_cols(input logic [7:0] v);
        if (v == 8'd0) begin
            return 8'd1;
        end else if (v > COLS_MAX) begin
            return COLS_MAX;
        end
        return v;
    endfunction

    function automatic logic [6:0] clamp_rows(input logic [6:0] v);
        if (v == 7'd0) begin
            return 7'd1;
        end else if (v > ROWS_MAX) begin
            return ROWS_MAX;
        end
        return v;
    endfunction

endpackage

FILE: src/ps2_mouse_text_cursor_core.sv
// Top level of the PS/2 mouse text cursor core: configuration and wiring.
//
// Use: feed one beat per controller read on the input channel (status byte
// and data byte). Beats whose status bit 5 is clear are taken and dropped.
// Mouse bytes build three-byte packets (buttons, dx, dy); each completed
// packet yields two to four cell-invert commands on the output channel,
// the last one flagged by o_is_last, all carrying the packet's buttons and
// the new cursor position.
// Flow: with the sequencer idle, the first command of a packet passes the
// packet queue, the sequencer's cell pass and the output register; the
// rest follow one per cycle while i_stall is low.
// Throughput: input beats are taken every cycle while the packet queue has
// room; the sequencer takes no new packet until the last of its n commands
// (at most 4) is loaded, paced by its shared cell multiplier pass and the
// one-command output register, so packets that arrive faster than it drains
// them fill the queue and the input then stalls.
// Stalling: the output register holds a command while i_stall is high; the
// two-entry packet queue absorbs the back-up, and o_stall rises only when
// that queue is full.
// Reset (synchronous, i_rst_n low): screen 80 x 25, cursor at column 40,
// row 12, click mark clear, packet assembly back at the first byte.
// Configuration: i_cfg_we writes screen_columns (index 0) or screen_rows
// (index 1); write only while the block is idle.
module ps2_mouse_text_cursor_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_status_byte,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [12:0] o_cell_index,
    output logic        o_is_last,
    output logic [7:0]  o_button_flags,
    output logic [6:0]  o_cursor_column,
    output logic [5:0]  o_cursor_row,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import ps2mtc_pkg::*;

    logic [7:0] r_screen_columns;
    logic [6:0] r_screen_rows;
    t_screen    w_screen;

    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_packet    w_pkt_in;
    t_packet    w_pkt_out;

    // Configuration registers; writes land immediately
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_columns <= COLS_RESET;
            r_screen_rows    <= ROWS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SCREEN_COLUMNS: r_screen_columns <= i_cfg_data;
                CFG_SCREEN_ROWS:    r_screen_rows    <= i_cfg_data[6:0];
                default:            ;
            endcase
        end
    end

    // Zero acts as one, oversize acts as the screen maximum
    assign w_screen = '{cols: clamp_cols(r_screen_columns),
                        rows: clamp_rows(r_screen_rows)};

    ps2mtc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_status_byte (i_status_byte),
        .i_data_byte   (i_data_byte),
        .o_push        (w_push),
        .o_packet      (w_pkt_in),
        .i_full        (w_full)
    );

    ps2mtc_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_packet (w_pkt_in),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_packet (w_pkt_out),
        .o_empty  (w_empty)
    );

    ps2mtc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_screen        (w_screen),
        .i_packet        (w_pkt_out),
        .i_empty         (w_empty),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_cell_index    (o_cell_index),
        .o_is_last       (o_is_last),
        .o_button_flags  (o_button_flags),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row)
    );

endmodule

FILE: src/ps2mtc_front.sv
// Front end: filters mouse bytes and assembles three-byte packets.
module ps2mtc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_status_byte,
    input  logic [7:0]          i_data_byte,
    output logic                o_push,
    output ps2mtc_pkg::t_packet o_packet,
    input  logic                i_full
);
    import ps2mtc_pkg::*;

    logic [1:0] r_pos;
    logic [1:0] n_pos;
    logic [7:0] r_b0;
    logic [7:0] r_b1;
    logic       w_take;

    // Hold every beat while the queue cannot take a packet
    assign o_stall = i_full;
    assign w_take  = i_valid && !i_full && i_status_byte[STATUS_MOUSE_BIT];

    always_comb begin
        n_pos  = r_pos;
        o_push = 1'b0;
        if (w_take) begin
            case (r_pos)
                2'd1:    n_pos = 2'd2;
                2'd2: begin
                    n_pos  = 2'd0;
                    o_push = 1'b1;
                end
                default: n_pos = 2'd1;
            endcase
        end
    end

    assign o_packet = '{buttons: r_b0, dx: r_b1, dy: i_data_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 2'd0;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            case (r_pos)
                2'd1:    r_b1 <= i_data_byte;
                2'd2:    ;
                default: r_b0 <= i_data_byte;
            endcase
        end
    end

endmodule

FILE: src/ps2mtc_fifo.sv
// Short packet queue between the front end and the command sequencer.
module ps2mtc_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  ps2mtc_pkg::t_packet i_packet,
    output logic                o_full,
    input  logic                i_pop,
    output ps2mtc_pkg::t_packet o_packet,
    output logic                o_empty
);
    import ps2mtc_pkg::*;

    t_packet              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_CW-1:0]   r_count;
    logic                 w_wr;
    logic                 w_rd;

    assign o_full   = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty  = (r_count == '0);
    assign o_packet = r_mem[r_rp];
    assign w_wr     = i_push && !o_full;
    assign w_rd     = i_pop && !o_empty;

    function automatic logic [FIFO_AW-1:0] bump(input logic [FIFO_AW-1:0] p);
        if (p == FIFO_AW'(FIFO_DEPTH - 1)) begin
            return '0;
        end
        return p + FIFO_AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= bump(r_wp);
            end
            if (w_rd) begin
                r_rp <= bump(r_rp);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_packet;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("fifo count beyond depth");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full && !w_rd |=> o_full)
        else $error("fifo lost an entry while full");
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> !o_empty)
        else $error("fifo empty after a push");

endmodule

FILE: src/ps2mtc_back.sv
// Back end: moves the cursor and issues cell-invert commands per packet.
module ps2mtc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ps2mtc_pkg::t_screen i_screen,
    input  ps2mtc_pkg::t_packet i_packet,
    input  logic                i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [12:0]         o_cell_index,
    output logic                o_is_last,
    output logic [7:0]          o_button_flags,
    output logic [6:0]          o_cursor_column,
    output logic [5:0]          o_cursor_row
);
    import ps2mtc_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CELL = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]  r_state;
    logic [6:0]  r_col;
    logic [5:0]  r_row;
    logic        r_mark;
    logic        r_mark_old;
    logic        r_btn_hit;
    logic [7:0]  r_flags;
    logic [12:0] r_old;
    logic [12:0] r_new;
    logic [2:0]  r_n;
    logic [1:0]  r_k;

    logic        r_ov;
    logic [12:0] r_o_cell;
    logic        r_o_last;
    logic [7:0]  r_o_flags;
    logic [6:0]  r_o_col;
    logic [5:0]  r_o_row;

    logic [13:0]       w_cell;
    logic signed [8:0] w_ncol_s;
    logic signed [8:0] w_nrow_s;
    logic [6:0]        w_ncol;
    logic [5:0]        w_nrow;
    logic              w_load;
    logic              w_last;
    logic [2:0]        w_n_old;

    // One multiplier serves both the old and the new cell
    assign w_cell = 14'(r_row) * 14'(i_screen.cols) + 14'(r_col);

    assign w_ncol_s = $signed({2'b00, r_col}) + $signed({i_packet.dx[7], i_packet.dx});
    assign w_nrow_s = $signed({3'b000, r_row}) - $signed({i_packet.dy[7], i_packet.dy});

    always_comb begin
        if (w_ncol_s < 0) begin
            w_ncol = 7'd0;
        end else if (w_ncol_s >= $signed({1'b0, i_screen.cols})) begin
            w_ncol = 7'(i_screen.cols - 8'd1);
        end else begin
            w_ncol = w_ncol_s[6:0];
        end
        if (w_nrow_s < 0) begin
            w_nrow = 6'd0;
        end else if (w_nrow_s >= $signed({2'b00, i_screen.rows})) begin
            w_nrow = 6'(i_screen.rows - 7'd1);
        end else begin
            w_nrow = w_nrow_s[5:0];
        end
    end

    assign o_pop   = (r_state == S_IDLE) && !i_empty;
    assign w_load  = (r_state == S_EMIT) && (!r_ov || !i_stall);
    assign w_last  = ({1'b0, r_k} == r_n - 3'd1);
    assign w_n_old = r_mark_old ? 3'd2 : 3'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col   <= COL_RESET;
            r_row   <= ROW_RESET;
            r_mark  <= 1'b0;
            r_ov    <= 1'b0;
            r_k     <= 2'd0;
            r_n     <= 3'd2;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        r_col   <= w_ncol;
                        r_row   <= w_nrow;
                        r_mark  <= |(i_packet.buttons & BUTTON_MASK);
                        r_state <= S_CELL;
                    end
                end
                S_CELL: begin
                    r_n     <= 3'd2 + {2'b00, r_mark_old} + {2'b00, r_btn_hit};
                    r_k     <= 2'd0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_k <= r_k + 2'd1;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            // Output register: fill on a new command, drop once taken
            if (w_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_old      <= w_cell[12:0];
            r_mark_old <= r_mark;
            r_btn_hit  <= |(i_packet.buttons & BUTTON_MASK);
            r_flags    <= i_packet.buttons;
        end
        if (r_state == S_CELL) begin
            r_new <= w_cell[12:0];
        end
        if (w_load) begin
            r_o_cell  <= ({1'b0, r_k} < w_n_old) ? r_old : r_new;
            r_o_last  <= w_last;
            r_o_flags <= r_flags;
            r_o_col   <= r_col;
            r_o_row   <= r_row;
        end
    end

    assign o_valid         = r_ov;
    assign o_cell_index    = r_o_cell;
    assign o_is_last       = r_o_last;
    assign o_button_flags  = r_o_flags;
    assign o_cursor_column = r_o_col;
    assign o_cursor_row    = r_o_row;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_n >= 3'd2 && r_n <= 3'd4 && {1'b0, r_k} < r_n))
        else $error("command slot out of range");
    a_pop_to_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == S_CELL))
        else $error("packet popped without cell pass");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load && w_last |=> (r_state == S_IDLE) && o_valid && o_is_last)
        else $error("last command did not close the packet");
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_cell_index) && $stable(o_cursor_column))
        else $error("stalled command changed");

endmodule
